// ===== hdl/gne_pkg.sv =====
// shared types, constants and tables of the grid neighbor expander
package gne_pkg;

  // grid limits
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;

  // field widths
  localparam int NODE_W    = 16;
  localparam int COST_W    = 15;
  localparam int CFG_DIM_W = 9;
  localparam int CFG_IDX_W = 2;
  localparam int MAP_DEPTH = 1 << NODE_W;

  // widths that follow from the grid limits and the node width
  localparam int W_BITS   = $clog2(MAX_WIDTH + 1);
  localparam int H_BITS   = $clog2(MAX_HEIGHT + 1);
  localparam int REM_W    = W_BITS + 1;
  localparam int ID_EXT_W = NODE_W + 1;

  // divider: two quotient bits per cycle
  localparam int DIV_STEPS = 2;
  localparam int DIV_ITERS = NODE_W / DIV_STEPS;
  localparam int DIV_CNT_W = $clog2(DIV_ITERS);

  // neighbor list: left, right, up, down, up-left, down-left, up-right, down-right
  localparam int NB_COUNT    = 8;
  localparam int NB_IDX_W    = 3;
  localparam int ORTHO_COUNT = 4;
  localparam int DIAG_COUNT  = 4;
  localparam logic signed [1:0] NB_DX [NB_COUNT] =
    '{-2'sd1, 2'sd1, 2'sd0, 2'sd0, -2'sd1, -2'sd1, 2'sd1, 2'sd1};
  localparam logic signed [1:0] NB_DY [NB_COUNT] =
    '{2'sd0, 2'sd0, -2'sd1, 2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd1};
  // orthogonal cells beside each diagonal (horizontal one, vertical one)
  localparam logic [NB_IDX_W-1:0] DIAG_SIDE_X [DIAG_COUNT] = '{3'd0, 3'd0, 3'd1, 3'd1};
  localparam logic [NB_IDX_W-1:0] DIAG_SIDE_Y [DIAG_COUNT] = '{3'd2, 3'd3, 3'd2, 3'd3};

  // move costs, unsigned Q1.14
  localparam logic [COST_W-1:0] COST_ORTHO = 15'd16384;
  localparam logic [COST_W-1:0] COST_DIAG  = 15'd23170;

  // commands
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_EXPAND = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MAP_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_EIGHT_CONN = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_SETTLE,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic [NODE_W-1:0] quot;
    logic [W_BITS-1:0] rem;
  } div_result_t;

endpackage

// ===== hdl/gne_ram.sv =====
// generic simple dual port ram with registered read
module gne_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/gne_divider.sv =====
// iterative restoring divider, splits a node id into row and column
module gne_divider (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [gne_pkg::NODE_W-1:0] dividend,
  input  logic [gne_pkg::W_BITS-1:0] divisor,
  output logic                       done,
  output gne_pkg::div_result_t       result
);
  import gne_pkg::*;

  logic                 busy;
  logic [DIV_CNT_W-1:0] cnt;
  logic [REM_W-1:0]     rem;
  logic [NODE_W-1:0]    quo;
  logic [W_BITS-1:0]    dvs;
  logic [REM_W-1:0]     rem_next;
  logic [NODE_W-1:0]    quo_next;

  // two restoring steps per cycle
  always_comb begin
    rem_next = rem;
    quo_next = quo;
    for (int i = 0; i < DIV_STEPS; i++) begin
      rem_next = {rem_next[REM_W-2:0], quo_next[NODE_W-1]};
      quo_next = {quo_next[NODE_W-2:0], 1'b0};
      if (rem_next >= {1'b0, dvs}) begin
        rem_next    = rem_next - {1'b0, dvs};
        quo_next[0] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        quo  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        quo <= quo_next;
        rem <= rem_next;
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_ITERS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign result.quot = quo;
  assign result.rem  = rem[W_BITS-1:0];

endmodule

// ===== hdl/grid_neighbor_expander_core.sv =====
// top level of the grid neighbor expander: control, neighbor walk and result register
//
// usage
// - input channel (in_valid/in_ready): one transaction is either a write of one
//   cell's walkable bit (command write) or an expansion of node_id (command expand)
// - a write is stored in the cycle it is taken and gives no result
// - an expansion runs the divider (eight two-bit steps, then done), reads the eight
//   neighbor cells from the map ram in turn, merges the last read, then emits one
//   result per cycle while out_ready is high (at most eight)
// - an expansion of a node off the map skips the map reads and emits its lone result
// - results come on the output channel (out_valid/out_ready) through one output
//   register; last marks the final result of an expansion, and a lone result with
//   found low means no neighbor or, with out_of_range, a node outside the map
// - in_ready is high only between expansions; the next transaction is taken while
//   the final result still waits in the output register
// - a stalled receiver holds the output register and pauses the result emission
// - configuration (cfg_write/cfg_index/cfg_data) must be written only while idle; the block does not enforce this
// - reset clears control state and restores width 256, height 256 and eight
//   connected mode; the walkable map itself is not cleared
module grid_neighbor_expander_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [gne_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gne_pkg::CFG_DIM_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          command,
  input  logic [gne_pkg::NODE_W-1:0]    node_id,
  input  logic                          walkable,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [gne_pkg::NODE_W-1:0]    neighbor_id,
  output logic [gne_pkg::COST_W-1:0]    step_cost,
  output logic                          found,
  output logic                          out_of_range,
  output logic                          last
);
  import gne_pkg::*;

  // configuration registers
  logic [CFG_DIM_W-1:0] cfg_width;
  logic [CFG_DIM_W-1:0] cfg_height;
  logic                 cfg_eight;

  // effective map size after clamping
  logic [W_BITS-1:0] w_eff;
  logic [H_BITS-1:0] h_eff;

  state_t state, state_next;

  // expansion context
  logic [NODE_W-1:0]   node;
  logic [W_BITS-1:0]   pos_x;
  logic [NODE_W-1:0]   pos_y;
  logic                oor_flag;
  logic [NB_IDX_W-1:0] rd_idx;
  logic                rd_pend;
  logic [NB_IDX_W-1:0] pend_idx;
  logic                pend_ok;
  logic [NB_COUNT-1:0] free;
  logic [NB_COUNT-1:0] free_all;
  logic [NB_COUNT-1:0] mask_all;
  logic [NB_COUNT-1:0] emit_mask;
  logic [NB_COUNT-1:0] mask_rest;
  logic [NB_IDX_W-1:0] pick_idx;

  // handshake and control
  logic in_fire;
  logic ram_we;
  logic div_start;
  logic div_done;
  div_result_t div_res;
  logic y_oor;
  logic out_free;
  logic out_load;
  logic emit_none;

  // neighbor address path
  logic [NB_IDX_W-1:0]  sel_idx;
  logic signed [1:0]    sel_dx;
  logic signed [1:0]    sel_dy;
  logic [ID_EXT_W-1:0]  node_ext;
  logic [ID_EXT_W-1:0]  w_ext;
  logic [ID_EXT_W-1:0]  row_id;
  logic [ID_EXT_W-1:0]  nb_id;
  logic                 at_left;
  logic                 at_right;
  logic                 at_top;
  logic                 at_bottom;
  logic                 nb_ok;
  logic                 ram_rdata;

  // zero reads as one, anything above the limit saturates
  always_comb begin
    if (cfg_width == '0) begin
      w_eff = W_BITS'(1);
    end else if (32'(cfg_width) > MAX_WIDTH) begin
      w_eff = W_BITS'(MAX_WIDTH);
    end else begin
      w_eff = W_BITS'(cfg_width);
    end
    if (cfg_height == '0) begin
      h_eff = H_BITS'(1);
    end else if (32'(cfg_height) > MAX_HEIGHT) begin
      h_eff = H_BITS'(MAX_HEIGHT);
    end else begin
      h_eff = H_BITS'(cfg_height);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_width  <= CFG_DIM_W'(256);
      cfg_height <= CFG_DIM_W'(256);
      cfg_eight  <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MAP_WIDTH:  cfg_width  <= cfg_data;
        REG_MAP_HEIGHT: cfg_height <= cfg_data;
        REG_EIGHT_CONN: cfg_eight  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // input side: writes go straight to the map, expansions start the divider
  assign in_ready  = (state == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign ram_we    = in_fire && (command == CMD_WRITE);
  assign div_start = in_fire && (command == CMD_EXPAND);

  gne_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (node_id),
    .divisor  (w_eff),
    .done     (div_done),
    .result   (div_res)
  );

  assign y_oor = 32'(div_res.quot) >= 32'(h_eff);

  // neighbor id: node plus or minus one row, then plus or minus one column
  assign sel_idx  = (state == ST_EMIT) ? pick_idx : rd_idx;
  assign sel_dx   = NB_DX[sel_idx];
  assign sel_dy   = NB_DY[sel_idx];
  assign node_ext = {1'b0, node};
  assign w_ext    = ID_EXT_W'(w_eff);

  always_comb begin
    if (sel_dy == -2'sd1) begin
      row_id = node_ext - w_ext;
    end else if (sel_dy == 2'sd1) begin
      row_id = node_ext + w_ext;
    end else begin
      row_id = node_ext;
    end
    if (sel_dx == -2'sd1) begin
      nb_id = row_id - ID_EXT_W'(1);
    end else if (sel_dx == 2'sd1) begin
      nb_id = row_id + ID_EXT_W'(1);
    end else begin
      nb_id = row_id;
    end
  end

  // map borders, plus ids past the end of storage count as blocked
  assign at_left   = (pos_x == '0);
  assign at_right  = (32'(pos_x) + 32'd1) >= 32'(w_eff);
  assign at_top    = (pos_y == '0);
  assign at_bottom = (32'(pos_y) + 32'd1) >= 32'(h_eff);
  assign nb_ok     = ((sel_dx != -2'sd1) || !at_left) &&
                     ((sel_dx != 2'sd1) || !at_right) &&
                     ((sel_dy != -2'sd1) || !at_top) &&
                     ((sel_dy != 2'sd1) || !at_bottom) &&
                     !nb_id[NODE_W];

  gne_ram #(
    .WIDTH (1),
    .DEPTH (MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (node_id),
    .wdata (walkable),
    .re    (state == ST_READ),
    .raddr (nb_id[NODE_W-1:0]),
    .rdata (ram_rdata)
  );

  // fold in the read that is still in flight
  always_comb begin
    free_all = free;
    if (rd_pend) begin
      free_all[pend_idx] = ram_rdata && pend_ok;
    end
  end

  // a diagonal also needs both orthogonal cells beside it
  always_comb begin
    mask_all = '0;
    for (int i = 0; i < ORTHO_COUNT; i++) begin
      mask_all[i] = free_all[i];
    end
    for (int i = 0; i < DIAG_COUNT; i++) begin
      mask_all[ORTHO_COUNT + i] = cfg_eight && free_all[ORTHO_COUNT + i] &&
                                  free_all[DIAG_SIDE_X[i]] && free_all[DIAG_SIDE_Y[i]];
    end
  end

  // lowest pending neighbor goes out next
  always_comb begin
    pick_idx = '0;
    for (int i = NB_COUNT - 1; i >= 0; i--) begin
      if (emit_mask[i]) begin
        pick_idx = NB_IDX_W'(i);
      end
    end
    mask_rest           = emit_mask;
    mask_rest[pick_idx] = 1'b0;
  end

  assign out_free  = !out_valid || out_ready;
  assign out_load  = (state == ST_EMIT) && out_free;
  assign emit_none = oor_flag || (emit_mask == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (div_start) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          state_next = y_oor ? ST_EMIT : ST_READ;
        end
      end
      ST_READ: begin
        if (rd_idx == NB_IDX_W'(NB_COUNT - 1)) begin
          state_next = ST_SETTLE;
        end
      end
      ST_SETTLE: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free && (emit_none || (mask_rest == '0))) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // expansion datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend   <= 1'b0;
      rd_idx    <= '0;
      oor_flag  <= 1'b0;
      emit_mask <= '0;
    end else begin
      rd_pend  <= (state == ST_READ);
      pend_idx <= rd_idx;
      pend_ok  <= nb_ok;
      if (div_start) begin
        node <= node_id;
      end
      if ((state == ST_DIV) && div_done) begin
        pos_x     <= div_res.rem;
        pos_y     <= div_res.quot;
        oor_flag  <= y_oor;
        emit_mask <= '0;
        rd_idx    <= '0;
      end
      if (state == ST_READ) begin
        rd_idx <= rd_idx + 1'b1;
      end
      if (rd_pend) begin
        free <= free_all;
      end
      if (state == ST_SETTLE) begin
        emit_mask <= mask_all;
      end else if (out_load && !emit_none) begin
        emit_mask <= mask_rest;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (emit_none) begin
        neighbor_id  <= '0;
        step_cost    <= '0;
        found        <= 1'b0;
        out_of_range <= oor_flag;
        last         <= 1'b1;
      end else begin
        neighbor_id  <= nb_id[NODE_W-1:0];
        step_cost    <= (32'(pick_idx) < ORTHO_COUNT) ? COST_ORTHO : COST_DIAG;
        found        <= 1'b1;
        out_of_range <= 1'b0;
        last         <= (mask_rest == '0);
      end
    end
  end

`ifndef ASSERT_OFF
  a_expand_starts_div: assert property (@(posedge clk) disable iff (rst)
    div_start |=> (state == ST_DIV))
    else $error("expand transaction did not start the divider phase");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside the divider phase");

  a_map_write_idle: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> ((state == ST_IDLE) && !rd_pend))
    else $error("map write while an expansion is in progress");

  a_found_cost: assert property (@(posedge clk) disable iff (rst)
    (out_valid && found) |-> (!out_of_range &&
      ((step_cost == COST_ORTHO) || (step_cost == COST_DIAG))))
    else $error("found result with bad cost or range flag");

  a_oor_single: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_of_range) |-> (last && !found))
    else $error("out of range result is not a lone final result");
`endif

endmodule

// ===== sim/grid_neighbor_expander_core_test.sv =====
// self-checking testbench of the grid neighbor expander: directed and random expansions
module grid_neighbor_expander_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import gne_pkg::*;

  localparam int MAP_CELLS    = 65536;
  localparam int DRAIN_CYCLES = 30;      // settling time after the last result
  localparam int MAX_REPORTS  = 10;

  // own move order: left, right, up, down, up-left, down-left, up-right, down-right
  localparam int MOVE_DX [8] = '{-1, 1, 0, 0, -1, -1, 1, 1};
  localparam int MOVE_DY [8] = '{0, 0, -1, 1, -1, 1, -1, 1};
  localparam logic [14:0] ORTHO_Q14 = 15'd16384;  // 1.0 in Q1.14
  localparam logic [14:0] DIAG_Q14  = 15'd23170;  // sqrt 2 in Q1.14, rounded

  // random phases: width and height register values, mode, item budget, idling on
  localparam int PH_COUNT = 8;
  localparam int PH_W    [PH_COUNT] = '{256, 1, 0, 511, 5, 16, 300, 1};
  localparam int PH_H    [PH_COUNT] = '{256, 1, 0, 511, 7, 4, 2, 256};
  localparam int PH_DIAG [PH_COUNT] = '{1, 1, 0, 0, 1, 0, 1, 1};
  localparam int PH_N    [PH_COUNT] = '{25, 12, 10, 20, 30, 25, 20, 20};
  localparam int PH_IDLE [PH_COUNT] = '{1, 1, 0, 1, 0, 1, 1, 1};

  // one result transaction
  typedef struct packed {
    logic [15:0] id;
    logic [14:0] cost;
    logic        found;
    logic        oor;
    logic        last;
  } neighbor_rec_t;

  // predicts the neighbor list of every expansion and checks results in order
  class neighbor_scoreboard;
    bit            free_map [MAP_CELLS];
    int            width_reg;
    int            height_reg;
    bit            diag_on;
    int            mismatch_count;
    neighbor_rec_t expected_neighbors[$];

    function new();
      width_reg      = 256;
      height_reg     = 256;
      diag_on        = 1'b1;
      mismatch_count = 0;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, int value);
      case (idx)
        REG_MAP_WIDTH:  width_reg  = value & 'h1FF;
        REG_MAP_HEIGHT: height_reg = value & 'h1FF;
        REG_EIGHT_CONN: diag_on    = value[0];
        default: ;
      endcase
    endfunction

    function int eff_width();
      if (width_reg == 0) return 1;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return width_reg;
    endfunction

    function int eff_height();
      if (height_reg == 0) return 1;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return height_reg;
    endfunction

    function bit open_cell(int cx, int cy, int w, int h);
      int cid;
      if (cx < 0 || cy < 0 || cx >= w || cy >= h) return 1'b0;
      cid = cy * w + cx;
      if (cid >= MAP_CELLS) return 1'b0;
      return free_map[cid];
    endfunction

    function int pending();
      return expected_neighbors.size();
    endfunction

    // accepted input: a write updates the map, an expansion queues its neighbor list
    function void note_transaction(logic cmd, logic [15:0] nid, logic wbit);
      int            w, h, x, y, nx, ny, k, hits;
      neighbor_rec_t rec;
      if (cmd == CMD_WRITE) begin
        free_map[nid] = wbit;
        return;
      end
      w = eff_width();
      h = eff_height();
      x = int'(nid) % w;
      y = int'(nid) / w;
      if (y >= h) begin
        rec = '{id: '0, cost: '0, found: 1'b0, oor: 1'b1, last: 1'b1};
        expected_neighbors.push_back(rec);
        return;
      end
      hits = 0;
      for (k = 0; k < 8; k++) begin
        nx = x + MOVE_DX[k];
        ny = y + MOVE_DY[k];
        if (k >= 4 && !diag_on) break;
        if (!open_cell(nx, ny, w, h)) continue;
        // no corner cutting: both side cells of a diagonal must be free
        if (k >= 4 && !(open_cell(nx, y, w, h) && open_cell(x, ny, w, h))) continue;
        rec = '{id: 16'(ny * w + nx), cost: (k < 4) ? ORTHO_Q14 : DIAG_Q14,
                found: 1'b1, oor: 1'b0, last: 1'b0};
        expected_neighbors.push_back(rec);
        hits++;
      end
      if (hits == 0) begin
        rec = '{id: '0, cost: '0, found: 1'b0, oor: 1'b0, last: 1'b1};
        expected_neighbors.push_back(rec);
      end else begin
        rec = expected_neighbors.pop_back();
        rec.last = 1'b1;
        expected_neighbors.push_back(rec);
      end
    endfunction

    function void check_result(neighbor_rec_t got);
      neighbor_rec_t want;
      if (expected_neighbors.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t unexpected result: id %0d cost %0d found %0b oor %0b last %0b",
                   $time, got.id, got.cost, got.found, got.oor, got.last);
        return;
      end
      want = expected_neighbors.pop_front();
      if (got.id !== want.id || got.cost !== want.cost || got.found !== want.found ||
          got.oor !== want.oor || got.last !== want.last) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t result mismatch: exp id %0d cost %0d found %0b oor %0b last %0b,",
                   $time, want.id, want.cost, want.found, want.oor, want.last,
                   " got id %0d cost %0d found %0b oor %0b last %0b",
                   got.id, got.cost, got.found, got.oor, got.last);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DIM_W-1:0] cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 command;
  logic [NODE_W-1:0]    node_id;
  logic                 walkable;
  logic                 out_valid;
  logic                 out_ready;
  logic [NODE_W-1:0]    neighbor_id;
  logic [COST_W-1:0]    step_cost;
  logic                 found;
  logic                 out_of_range;
  logic                 last;

  neighbor_scoreboard board;
  bit                 cell_written [MAP_CELLS];  // cells stored so far, never read before
  bit                 tx_idle;
  bit                 rx_idle;
  int                 items_sent;                // accepted input transactions, fills included

  grid_neighbor_expander_core u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .command      (command),
    .node_id      (node_id),
    .walkable     (walkable),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .neighbor_id  (neighbor_id),
    .step_cost    (step_cost),
    .found        (found),
    .out_of_range (out_of_range),
    .last         (last)
  );

  // 100 MHz clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  // receiver: random stall before each result while rx_idle is set, ready held until a transaction
  initial begin
    int stall;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      stall = rx_idle ? $urandom_range(0, 9) : 0;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // result monitor, sampled at the rising edge
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_result('{id: neighbor_id, cost: step_cost, found: found,
                           oor: out_of_range, last: last});
  end

  // one input transaction after a random gap while tx_idle is set; valid holds until accepted
  task automatic send_item(input logic cmd, input logic [15:0] nid, input logic wbit);
    int gap;
    gap = tx_idle ? $urandom_range(0, 9) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    command  <= cmd;
    node_id  <= nid;
    walkable <= wbit;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    board.note_transaction(cmd, nid, wbit);
    items_sent++;
  endtask

  task automatic put_cell(input logic [15:0] nid, input logic wbit);
    cell_written[nid] = 1'b1;
    send_item(CMD_WRITE, nid, wbit);
  endtask

  // fill any unwritten cell around the node first (mostly free), then expand it
  task automatic expand_at(input logic [15:0] nid);
    int w, dx, dy, raw;
    w = board.eff_width();
    for (dy = -1; dy <= 1; dy++) begin
      for (dx = -1; dx <= 1; dx++) begin
        raw = int'(nid) + dy * w + dx;
        if (raw >= 0 && raw < MAP_CELLS && !cell_written[raw])
          put_cell(16'(raw), $urandom_range(0, 3) != 0);
      end
    end
    send_item(CMD_EXPAND, nid, 1'($urandom_range(0, 1)));
  endtask

  // stop sending, wait for every result, then let the block settle
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_register(input logic [CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DIM_W'(value);
    @(negedge clk);
    cfg_write <= 1'b0;
    board.set_register(idx, value);
  endtask

  task automatic program_map(input int w, input int h, input int diag);
    set_register(REG_MAP_WIDTH, w);
    set_register(REG_MAP_HEIGHT, h);
    set_register(REG_EIGHT_CONN, diag);
  endtask

  // random mix: mostly in-map expansions leaning to the borders, some writes and
  // some expansions of arbitrary or off-map ids; count is a budget of input
  // transactions, neighbor fills included
  task automatic random_items(input int count, input bit pause_midway);
    int            first, w, h, x, y, pick;
    bit            paused;
    logic [15:0]   nid;
    first  = items_sent;
    paused = 1'b0;
    while (items_sent - first < count) begin
      if (pause_midway && !paused && items_sent - first >= count / 2) begin
        wait_drained();
        paused = 1'b1;
      end
      w = board.eff_width();
      h = board.eff_height();
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        if ($urandom_range(0, 1) != 0) nid = 16'($urandom_range(0, MAP_CELLS - 1));
        else nid = 16'($urandom_range(0, w * h - 1));
        put_cell(nid, 1'($urandom_range(0, 1)));
      end else if (pick < 24) begin
        if (w * h < MAP_CELLS && $urandom_range(0, 1) != 0)
          nid = 16'($urandom_range(w * h, MAP_CELLS - 1));
        else
          nid = 16'($urandom_range(0, MAP_CELLS - 1));
        expand_at(nid);
      end else begin
        if ($urandom_range(0, 3) == 0) x = ($urandom_range(0, 1) != 0) ? w - 1 : 0;
        else x = $urandom_range(0, w - 1);
        if ($urandom_range(0, 3) == 0) y = ($urandom_range(0, 1) != 0) ? h - 1 : 0;
        else y = $urandom_range(0, h - 1);
        expand_at(16'(y * w + x));
      end
    end
  endtask

  initial begin
    int p, c;
    board      = new();
    rst        = 1'b1;
    cfg_write  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    in_valid   = 1'b0;
    command    = CMD_WRITE;
    node_id    = '0;
    walkable   = 1'b0;
    tx_idle    = 1'b1;
    rx_idle    = 1'b1;
    items_sent = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: 3x3 map, eight-connected, everything free
    program_map(3, 3, 1);
    for (c = 0; c < 9; c++) put_cell(16'(c), 1'b1);
    put_cell(16'hFFFF, 1'b0);        // top id, far outside the map
    expand_at(16'd4);                // center: all eight moves, orthogonal first
    expand_at(16'd0);                // top-left corner
    expand_at(16'd8);                // bottom-right corner
    expand_at(16'd9);                // first row past the map
    expand_at(16'hFFFF);             // top id, off the map
    put_cell(16'd1, 1'b0);           // block up: up-left and up-right lose a side
    expand_at(16'd4);
    put_cell(16'd3, 1'b0);
    put_cell(16'd5, 1'b0);
    put_cell(16'd7, 1'b0);
    expand_at(16'd4);                // corners free but every side blocked: no neighbor
    wait_drained();

    // directed: four-connected mode
    set_register(REG_EIGHT_CONN, 0);
    put_cell(16'd1, 1'b1);
    expand_at(16'd0);                // right only, free diagonal not offered
    expand_at(16'd4);                // up only
    wait_drained();

    // random phases over several map shapes, extremes included
    for (p = 0; p < PH_COUNT; p++) begin
      program_map(PH_W[p], PH_H[p], PH_DIAG[p]);
      tx_idle = PH_IDLE[p];
      rx_idle = PH_IDLE[p];
      random_items(PH_N[p], 1'b0);
      wait_drained();
    end

    // last phase: random small map, sender pauses halfway until all results are in
    program_map($urandom_range(1, 64), $urandom_range(1, 64), $urandom_range(0, 1));
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    random_items(30, 1'b1);
    wait_drained();

    if (board.mismatch_count == 0 && board.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
